// File: sv/psev_pkg.sv
`default_nettype none

package psev_pkg;

  // token codes
  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  // step status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DIVZERO  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADOP    = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  // write-back result source
  localparam logic [1:0] WB_SUM = 2'd0;
  localparam logic [1:0] WB_MUL = 2'd1;
  localparam logic [1:0] WB_DIV = 2'd2;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned QUO_W   = 48;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       rd;
    logic       mul_go;
    logic       div_go;
    logic       wb;
    logic [1:0] wb_sel;
    logic       finish;
    logic [2:0] status;
  } psev_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       ge2;
    logic       top_zero;
    logic       sat;
    logic       div_done;
  } psev_stat_t;

endpackage

`default_nettype wire

// File: sv/psev_div.sv
`default_nettype none

module psev_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [psev_pkg::QUO_W-1:0]  dividend,
  input  wire logic [psev_pkg::DATA_W-1:0] divisor,
  output logic                             done,
  output logic [psev_pkg::QUO_W-1:0]       quotient
);
  import psev_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r;
  logic [QUO_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // restoring step: one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, sh_r[QUO_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? DATA_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DATA_W-1:0];
    sh_nxt  = {sh_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

`default_nettype wire

// File: sv/psev_dp.sv
`default_nettype none

module psev_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire psev_pkg::psev_cmd_t           cmd,
  output psev_pkg::psev_stat_t               stat,
  input  wire logic [2:0]                    in_func,
  input  wire logic signed [31:0]            in_operand_value,
  output logic                               out_valid,
  output logic signed [31:0]                 out_top_value,
  output logic [psev_pkg::DEPTH_W-1:0]       out_stack_depth,
  output logic [2:0]                         out_status
);
  import psev_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned RW = 49;

  // entries below the top live in memory, the top lives in top_r
  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]        count_r;
  logic [DATA_W-1:0]    top_r;
  logic [DATA_W-1:0]    rd_data_r;
  logic [2:0]           func_r;
  logic [DATA_W-1:0]    opnd_r;
  logic                 sat_r;
  logic signed [63:0]   prod_r;
  logic                 valid_r;
  logic [DATA_W-1:0]    out_top_r;
  logic [DEPTH_W-1:0]   out_depth_r;
  logic [2:0]           out_status_r;

  logic [CW-1:0]        wr_cnt, rd_cnt;
  logic [AW-1:0]        wr_idx, rd_idx;
  logic signed [RW-1:0] res_wide;
  logic [DATA_W-1:0]    res_clamp;
  logic                 res_sat;
  logic [DATA_W-1:0]    mag_a, mag_b;
  logic                 div_neg;
  logic                 div_done;
  logic [QUO_W-1:0]     quo;
  logic signed [RW-1:0] quo_s;

  assign wr_cnt = count_r - CW'(1);
  assign rd_cnt = count_r - CW'(2);
  assign wr_idx = wr_cnt[AW-1:0];
  assign rd_idx = rd_cnt[AW-1:0];

  // operand magnitudes for the divider, a is below the top, b is the top
  assign mag_a   = rd_data_r[DATA_W-1] ? DATA_W'(-rd_data_r) : rd_data_r;
  assign mag_b   = top_r[DATA_W-1] ? DATA_W'(-top_r) : top_r;
  assign div_neg = rd_data_r[DATA_W-1] ^ top_r[DATA_W-1];

  psev_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend ({mag_a, 16'd0}),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_s = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // result selection, everything sign extended to a common width
  always_comb begin
    case (cmd.wb_sel)
      WB_SUM: begin
        if (func_r == FN_SUB)
          res_wide = RW'($signed(rd_data_r)) - RW'($signed(top_r));
        else
          res_wide = RW'($signed(rd_data_r)) + RW'($signed(top_r));
      end
      WB_MUL:  res_wide = RW'($signed(prod_r[63:16]));
      WB_DIV:  res_wide = quo_s;
      default: res_wide = '0;
    endcase
  end

  // saturate to q16.16 range
  always_comb begin
    if ((&res_wide[RW-1:DATA_W-1]) || !(|res_wide[RW-1:DATA_W-1])) begin
      res_clamp = res_wide[DATA_W-1:0];
      res_sat   = 1'b0;
    end else begin
      res_clamp = res_wide[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      res_sat   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && count_r != '0)
      mem[wr_idx] <= top_r;
    if (cmd.rd)
      rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
      if (cmd.load)
        sat_r <= 1'b0;
      if (cmd.push)
        count_r <= count_r + CW'(1);
      if (cmd.wb) begin
        count_r <= wr_cnt;
        sat_r   <= res_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      opnd_r <= in_operand_value;
    end
    if (cmd.push)
      top_r <= opnd_r;
    if (cmd.wb)
      top_r <= res_clamp;
    if (cmd.mul_go)
      prod_r <= $signed(rd_data_r) * $signed(top_r);
    if (cmd.finish) begin
      out_top_r    <= (count_r == '0) ? '0 : top_r;
      out_depth_r  <= DEPTH_W'(count_r);
      out_status_r <= cmd.status;
    end
  end

  always_comb begin
    stat.func     = func_r;
    stat.full     = (count_r == CW'(STACK_DEPTH));
    stat.ge2      = (count_r >= CW'(2));
    stat.top_zero = (top_r == '0);
    stat.sat      = sat_r;
    stat.div_done = div_done;
  end

  assign out_valid       = valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

// File: sv/psev_ctrl.sv
`default_nettype none

module psev_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire psev_pkg::psev_stat_t stat,
  output psev_pkg::psev_cmd_t       cmd
);
  import psev_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_OPA  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.func == FN_PUSH) begin
          if (stat.full)
            st_nxt = ST_FULL;
          else
            cmd.push = 1'b1;
          state_nxt = S_OUT;
        end else if (stat.func > FN_DIV) begin
          st_nxt    = ST_BADOP;
          state_nxt = S_OUT;
        end else if (!stat.ge2) begin
          st_nxt    = ST_UNDERFLOW;
          state_nxt = S_OUT;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_OPA;
        end
      end
      S_OPA: begin
        case (stat.func)
          FN_ADD, FN_SUB: begin
            cmd.wb     = 1'b1;
            cmd.wb_sel = WB_SUM;
            state_nxt  = S_OUT;
          end
          FN_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt  = S_MUL;
          end
          FN_DIV: begin
            if (stat.top_zero) begin
              st_nxt    = ST_DIVZERO;
              state_nxt = S_OUT;
            end else begin
              cmd.div_go = 1'b1;
              state_nxt  = S_DIV;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_MUL: begin
        cmd.wb     = 1'b1;
        cmd.wb_sel = WB_MUL;
        state_nxt  = S_OUT;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.wb     = 1'b1;
          cmd.wb_sel = WB_DIV;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        cmd.finish = 1'b1;
        cmd.status = (st_r == ST_OK && stat.sat) ? ST_SAT : st_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: sv/postfix_stack_evaluator.sv
`default_nettype none

// postfix evaluator on a bounded stack of signed q16.16 values. a token is
// taken when start is high and busy is low; exactly one result beat follows,
// shown for one cycle with out_valid high, and the receiver cannot stall it,
// so it must take every beat as it comes. after the accepting edge the token
// passes the decode state; a push or any error that is found at decode goes
// straight to the report state, add, subtract and divide by zero go through
// the operand fetch state, multiply adds one registered 32x32 multiply, and
// divide waits for the restoring divider, which produces one of 48 quotient
// bits per cycle. busy stays high until the cycle in which the result is
// shown, so the next token can be accepted in that same cycle.
// func codes: 0 push, 1 add, 2 subtract, 3 multiply, 4 divide, others bad.
// status codes: 0 ok, 1 divide by zero, 2 underflow, 3 full, 4 bad operator,
// 5 saturated. any error leaves the stack untouched; saturation stores the
// clamped value. out_stack_depth is the entry count masked to 5 bits and
// out_top_value reads zero on an empty stack.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // token channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              in_func,
  input  wire logic signed [31:0]      in_operand_value,
  // result channel
  output logic                         out_valid,
  output logic signed [31:0]           out_top_value,
  output logic [4:0]                   out_stack_depth,
  output logic [2:0]                   out_status
);
  import psev_pkg::*;

  psev_cmd_t  cmd;
  psev_stat_t stat;

  // sequencer: decode, operand fetch, execute, report
  psev_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // stack memory, top register, alu, multiplier, divider, result beat
  psev_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_top_value    (out_top_value),
    .out_stack_depth  (out_stack_depth),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire
